// File: src/flrmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flrmh_pkg
// Shared types, constants and helpers for the four-lane multiply-rotate
// 64-bit hash block and its shared multiplier.
// ----------------------------------------------------------------------------
package flrmh_pkg;

    // hash multipliers
    localparam logic [63:0] PHI_K = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_A = 64'h85EB_CA77_C2B2_AE3D;
    localparam logic [63:0] MIX_B = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_C = 64'h94D0_49BB_1331_11EB;

    // apb register map: one 64-bit register at byte address 0
    localparam int          APB_ADDR_W = 4;
    localparam int          APB_DATA_W = 64;
    localparam logic [0:0]  REG_SEED   = 1'b0;

    // transaction function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_LANE_MUL,
        ST_ABSORB,
        ST_FOLD,
        ST_FIN_MUL,
        ST_OUT
    } state_t;

    // partial product steps of the shared multiplier
    typedef enum logic [1:0] {
        PP_LO_LO,
        PP_LO_HI,
        PP_HI_LO
    } pp_step_t;

    // request to the shared multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    // rotate a word left by the amount of its lane
    function automatic logic [63:0] lane_rotate(input logic [63:0] w,
                                                input logic [1:0]  idx);
        logic [63:0] r;
        unique case (idx)
            2'd0:    r = {w[52:0], w[63:53]};
            2'd1:    r = {w[44:0], w[63:45]};
            2'd2:    r = {w[28:0], w[63:29]};
            default: r = {w[16:0], w[63:17]};
        endcase
        return r;
    endfunction

    // seeding multiplier of each lane
    function automatic logic [63:0] lane_mult(input logic [1:0] idx);
        logic [63:0] m;
        unique case (idx)
            2'd0:    m = PHI_K;
            2'd1:    m = MIX_A;
            2'd2:    m = MIX_B;
            default: m = MIX_C;
        endcase
        return m;
    endfunction

    // keep the low n bytes of a word
    function automatic logic [63:0] tail_mask(input logic [2:0] n);
        logic [63:0] m;
        unique case (n)
            3'd0:    m = 64'h0000_0000_0000_0000;
            3'd1:    m = 64'h0000_0000_0000_00FF;
            3'd2:    m = 64'h0000_0000_0000_FFFF;
            3'd3:    m = 64'h0000_0000_00FF_FFFF;
            3'd4:    m = 64'h0000_0000_FFFF_FFFF;
            3'd5:    m = 64'h0000_00FF_FFFF_FFFF;
            3'd6:    m = 64'h0000_FFFF_FFFF_FFFF;
            default: m = 64'h00FF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// File: src/four_lane_multiply_rotate_hash64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_lane_multiply_rotate_hash64
// Four-lane multiply-rotate 64-bit hash over a message streamed as
// little-endian 64-bit words, computed on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_func, s_data_word, s_total_length
//  m_        out        m_valid / m_ready      m_hash_value
//  apb       in         psel/penable/pready    paddr, pwdata, prdata (seed_value)
//
//  Every 64-bit multiply runs on the shared 32x32 multiplier.
//  Start transaction: 5 multiplies, plus the final mix when length is 0.
//  Data word: one multiply; the last word adds the final mix.
//  s_ready is low while a transaction is being worked; a held result in the
//  output register stalls the block only when the next hash is ready.
//  aresetn is synchronous; the seed and the lanes reset to zero.
// ----------------------------------------------------------------------------
module four_lane_multiply_rotate_hash64 (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_func,
    input  logic [63:0]                          s_data_word,
    input  logic [31:0]                          s_total_length,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [63:0]                          m_hash_value,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [flrmh_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [flrmh_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [flrmh_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import flrmh_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    logic [63:0] seed_reg;
    logic [63:0] lane_reg  [0:3];
    logic [63:0] lane_next [0:3];
    logic [63:0] h_reg;
    logic [63:0] h_next;
    logic [31:0] bytes_left_reg;
    logic [31:0] bytes_left_next;
    logic [1:0]  block_pos_reg;
    logic [1:0]  block_pos_next;
    logic        open_reg;
    logic        open_next;
    logic [1:0]  lane_idx_reg;
    logic [1:0]  lane_idx_next;
    logic [1:0]  round_reg;
    logic [1:0]  round_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [63:0] m_hash_reg;
    logic [63:0] m_hash_next;

    mul_req_t    mul_req;
    logic        mul_done;
    logic [63:0] mul_product;

    logic        blk_path;
    logic        whole_word;
    logic [1:0]  absorb_idx;
    logic [63:0] absorb_word;
    logic [63:0] absorb_operand;
    logic [31:0] bytes_after;
    logic [63:0] fold;
    logic [63:0] seed_base;
    logic        cfg_write;

    flrmh_mul u_mul (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .mul_req     (mul_req),
        .mul_done    (mul_done),
        .mul_product (mul_product)
    );

    // apb register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[3] == REG_SEED) ? seed_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_write && paddr[3] == REG_SEED) begin
            seed_reg <= pwdata;
        end
    end

    // data word routing: block lane, whole word or masked tail
    assign blk_path       = (block_pos_reg != 2'd0) || (bytes_left_reg >= 32'd32);
    assign whole_word     = bytes_left_reg >= 32'd8;
    assign absorb_idx     = blk_path ? block_pos_reg : 2'd0;
    assign absorb_word    = (blk_path || whole_word) ? s_data_word
                          : (s_data_word & tail_mask(bytes_left_reg[2:0]));
    assign absorb_operand = lane_reg[absorb_idx] ^ lane_rotate(absorb_word, absorb_idx);
    assign bytes_after    = (blk_path || whole_word) ? (bytes_left_reg - 32'd8) : 32'd0;

    // lane fold and seed base
    assign fold      = lane_reg[0] ^ lane_reg[1] ^ lane_reg[2] ^ lane_reg[3];
    assign seed_base = seed_reg ^ mul_product;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

    // sequencer: next state, multiplier requests and datapath updates
    always_comb begin
        state_next      = state_reg;
        lane_next       = lane_reg;
        h_next          = h_reg;
        bytes_left_next = bytes_left_reg;
        block_pos_next  = block_pos_reg;
        open_next       = open_reg;
        lane_idx_next   = lane_idx_reg;
        round_next      = round_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_hash_next     = m_hash_reg;
        mul_req.start   = 1'b0;
        mul_req.a       = h_reg;
        mul_req.b       = PHI_K;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_func == FUNC_START) begin
                        bytes_left_next = s_total_length;
                        block_pos_next  = 2'd0;
                        open_next       = 1'b0;
                        mul_req.start   = 1'b1;
                        mul_req.a       = {32'h0, s_total_length};
                        mul_req.b       = PHI_K;
                        state_next      = ST_SEED_MUL;
                    end else if (open_reg) begin
                        mul_req.start   = 1'b1;
                        mul_req.a       = absorb_operand;
                        mul_req.b       = PHI_K;
                        lane_idx_next   = absorb_idx;
                        bytes_left_next = bytes_after;
                        block_pos_next  = blk_path ? (block_pos_reg + 2'd1) : block_pos_reg;
                        if (bytes_after == 32'd0) begin
                            open_next      = 1'b0;
                            block_pos_next = 2'd0;
                        end
                        state_next      = ST_ABSORB;
                    end
                end
            end
            ST_SEED_MUL: begin
                if (mul_done) begin
                    h_next        = seed_base;
                    mul_req.start = 1'b1;
                    mul_req.a     = seed_base;
                    mul_req.b     = lane_mult(2'd0);
                    lane_idx_next = 2'd0;
                    state_next    = ST_LANE_MUL;
                end
            end
            ST_LANE_MUL: begin
                if (mul_done) begin
                    lane_next[lane_idx_reg] = mul_product;
                    if (lane_idx_reg == 2'd3) begin
                        if (bytes_left_reg == 32'd0) begin
                            state_next = ST_FOLD;
                        end else begin
                            open_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end else begin
                        lane_idx_next = lane_idx_reg + 2'd1;
                        mul_req.start = 1'b1;
                        mul_req.a     = h_reg;
                        mul_req.b     = lane_mult(lane_idx_reg + 2'd1);
                    end
                end
            end
            ST_ABSORB: begin
                if (mul_done) begin
                    lane_next[lane_idx_reg] = mul_product;
                    state_next = (bytes_left_reg == 32'd0) ? ST_FOLD : ST_IDLE;
                end
            end
            ST_FOLD: begin
                mul_req.start = 1'b1;
                mul_req.a     = fold ^ (fold >> 29);
                mul_req.b     = MIX_A;
                round_next    = 2'd0;
                state_next    = ST_FIN_MUL;
            end
            ST_FIN_MUL: begin
                if (mul_done) begin
                    unique case (round_reg)
                        2'd0: begin
                            mul_req.start = 1'b1;
                            mul_req.a     = mul_product ^ (mul_product >> 31);
                            mul_req.b     = MIX_B;
                            round_next    = 2'd1;
                        end
                        2'd1: begin
                            mul_req.start = 1'b1;
                            mul_req.a     = mul_product ^ (mul_product >> 37);
                            mul_req.b     = PHI_K;
                            round_next    = 2'd2;
                        end
                        default: begin
                            h_next     = mul_product ^ (mul_product >> 41);
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_OUT: begin
                // load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_hash_next  = h_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control and lane registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg       <= '{default: '0};
            bytes_left_reg <= '0;
            block_pos_reg  <= '0;
            open_reg       <= 1'b0;
            lane_idx_reg   <= '0;
            round_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            lane_reg       <= lane_next;
            bytes_left_reg <= bytes_left_next;
            block_pos_reg  <= block_pos_next;
            open_reg       <= open_next;
            lane_idx_reg   <= lane_idx_next;
            round_reg      <= round_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        h_reg      <= h_next;
        m_hash_reg <= m_hash_next;
    end

    // multiplier results only arrive while the sequencer waits for one
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_SEED_MUL || state_reg == ST_LANE_MUL ||
                      state_reg == ST_ABSORB || state_reg == ST_FIN_MUL))
        else $error("multiplier result outside a wait state");

    // an open message always has bytes outstanding
    a_open_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg |-> (bytes_left_reg != 32'd0))
        else $error("message open with no bytes left");

    // every absorbed word consumes bytes
    a_data_consumes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func == FUNC_DATA && open_reg)
        |=> (bytes_left_reg < $past(bytes_left_reg)))
        else $error("data word did not consume bytes");

    // a new result only comes from the output state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

endmodule

// File: src/flrmh_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flrmh_mul
// Shared 64x64 multiplier, low 64 bits of the product, built from one
// 32x32 multiplier used for three partial products in turn.
// ----------------------------------------------------------------------------
module flrmh_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  flrmh_pkg::mul_req_t mul_req,
    output logic                mul_done,
    output logic [63:0]         mul_product
);
    import flrmh_pkg::*;

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    pp_step_t    step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] x_op;
    logic [31:0] y_op;
    logic [63:0] pp;

    // operand halves for the current partial product
    always_comb begin
        unique case (step_reg)
            PP_LO_LO: begin
                x_op = a_reg[31:0];
                y_op = b_reg[31:0];
            end
            PP_LO_HI: begin
                x_op = a_reg[31:0];
                y_op = b_reg[63:32];
            end
            PP_HI_LO: begin
                x_op = a_reg[63:32];
                y_op = b_reg[31:0];
            end
            default: begin
                x_op = a_reg[31:0];
                y_op = b_reg[31:0];
            end
        endcase
    end

    assign pp = 64'(x_op) * 64'(y_op);

    // low product first, cross terms land in the upper half
    always_comb begin
        if (step_reg == PP_LO_LO) begin
            acc_next = pp;
        end else begin
            acc_next = acc_reg + {pp[31:0], 32'h0};
        end
    end

    // operand capture and step sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= PP_LO_LO;
        end else begin
            done_reg <= 1'b0;
            if (mul_req.start) begin
                busy_reg <= 1'b1;
                step_reg <= PP_LO_LO;
            end else if (busy_reg) begin
                unique case (step_reg)
                    PP_LO_LO: step_reg <= PP_LO_HI;
                    PP_LO_HI: step_reg <= PP_HI_LO;
                    default: begin
                        step_reg <= PP_LO_LO;
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                endcase
            end
        end
    end

    // product datapath
    always_ff @(posedge aclk) begin
        if (mul_req.start) begin
            a_reg <= mul_req.a;
            b_reg <= mul_req.b;
        end
        if (busy_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign mul_done    = done_reg;
    assign mul_product = acc_reg;

endmodule

// File: verif/four_lane_multiply_rotate_hash64_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_lane_multiply_rotate_hash64_tb
// Self-checking bench for the four-lane multiply-rotate hash. A queue-fed
// driver offers start and data transactions in random bursts. Each accepted
// transaction runs through a local lane model, which queues the hash it
// should produce. A monitor compares every delivered hash against that queue
// while the sink, in most phases, stalls on a random ready pattern. The seed register is
// rewritten over apb between phases, including once in the middle of an open
// message. One phase holds the sink off for a long stretch.
// ----------------------------------------------------------------------------
module four_lane_multiply_rotate_hash64_tb;
    import flrmh_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 275;
    localparam logic [APB_ADDR_W-1:0] SEED_ADDR = APB_ADDR_W'(REG_SEED) << 3;

    // one input transaction
    typedef struct packed {
        logic        func;
        logic [63:0] word;
        logic [31:0] len;
    } hash_txn_t;

    logic                  aclk;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic                  s_func         = FUNC_START;
    logic [63:0]           s_data_word    = '0;
    logic [31:0]           s_total_length = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [63:0]           m_hash_value;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [APB_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // stimulus and scoreboard storage
    hash_txn_t   pending_txns[$];
    logic [63:0] expected_hashes[$];
    hash_txn_t   next_txn;
    logic [63:0] want_hash;
    int unsigned txn_queued    = 0;
    int unsigned txn_taken     = 0;
    int unsigned counted_items = 0;
    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;
    bit          gen_open      = 1'b0;

    // sender and sink idling controls
    bit          sender_gaps_on = 1'b1;
    bit          sink_stalls_on = 1'b1;
    int unsigned burst_left     = 0;
    int unsigned gap_left       = 0;
    int unsigned hold_requests  = 0;
    int unsigned hold_served    = 0;
    int unsigned hold_left      = 0;
    logic [31:0] ready_bits     = '1;
    logic [4:0]  ready_phase    = '0;

    // lane model state
    logic [63:0] seed_model     = '0;
    logic [63:0] lane_acc [4]   = '{default: '0};
    logic [31:0] bytes_pending  = '0;
    logic [1:0]  block_lane     = '0;
    bit          msg_open       = 1'b0;

    four_lane_multiply_rotate_hash64 i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_data_word    (s_data_word),
        .s_total_length (s_total_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // lane model
    // ------------------------------------------------------------------------

    function automatic logic [63:0] rotl64(input logic [63:0] w, input int unsigned k);
        return (w << k) | (w >> (64 - k));
    endfunction

    // rotate amount of each lane inside a block
    function automatic int unsigned lane_rot(input logic [1:0] idx);
        unique case (idx)
            2'd0:    return 11;
            2'd1:    return 19;
            2'd2:    return 35;
            default: return 47;
        endcase
    endfunction

    function automatic logic [63:0] absorb_word(input logic [63:0] lane,
                                                input logic [63:0] word,
                                                input int unsigned k);
        return (lane ^ rotl64(word, k)) * PHI_K;
    endfunction

    // xor-fold the lanes and run the final mix
    function automatic logic [63:0] fold_lanes();
        logic [63:0] h;
        h = lane_acc[0] ^ lane_acc[1] ^ lane_acc[2] ^ lane_acc[3];
        h = h ^ (h >> 29);
        h = h * MIX_A;
        h = h ^ (h >> 31);
        h = h * MIX_B;
        h = h ^ (h >> 37);
        h = h * PHI_K;
        h = h ^ (h >> 41);
        return h;
    endfunction

    // advance the model by one accepted transaction
    task automatic predict_txn(input logic func, input logic [63:0] word,
                               input logic [31:0] len);
        logic [63:0] base;
        logic [63:0] kept;
        if (func == FUNC_START) begin
            base          = seed_model ^ ({32'b0, len} * PHI_K);
            lane_acc[0]   = base * PHI_K;
            lane_acc[1]   = base * MIX_A;
            lane_acc[2]   = base * MIX_B;
            lane_acc[3]   = base * MIX_C;
            bytes_pending = len;
            block_lane    = '0;
            msg_open      = (len != 0);
            if (len == 0)
                expected_hashes.push_back(fold_lanes());
        end else if (msg_open) begin
            if (block_lane != 0 || bytes_pending >= 32) begin
                lane_acc[block_lane] = absorb_word(lane_acc[block_lane], word,
                                                   lane_rot(block_lane));
                block_lane    = block_lane + 2'd1;
                bytes_pending = bytes_pending - 8;
            end else if (bytes_pending >= 8) begin
                lane_acc[0]   = absorb_word(lane_acc[0], word, lane_rot(2'd0));
                bytes_pending = bytes_pending - 8;
            end else begin
                // tail word keeps only its remaining low bytes
                kept          = word & ((64'd1 << (8 * bytes_pending)) - 64'd1);
                lane_acc[0]   = absorb_word(lane_acc[0], kept, lane_rot(2'd0));
                bytes_pending = '0;
            end
            if (bytes_pending == 0) begin
                msg_open   = 1'b0;
                block_lane = '0;
                expected_hashes.push_back(fold_lanes());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued transactions in bursts with random gaps
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_txn(s_func, s_data_word, s_total_length);
                txn_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_txns.size() != 0) begin
                    next_txn = pending_txns.pop_front();
                    s_valid        <= 1'b1;
                    s_func         <= next_txn.func;
                    s_data_word    <= next_txn.word;
                    s_total_length <= next_txn.len;
                    // burst bookkeeping
                    if (sender_gaps_on) begin
                        if (burst_left != 0) begin
                            burst_left--;
                        end else begin
                            burst_left = $urandom_range(0, 11);
                            gap_left   = ($urandom_range(0, 7) == 0) ?
                                         $urandom_range(12, 40) : $urandom_range(1, 8);
                        end
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sink: random ready pattern, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            hold_left   = 0;
            hold_served = 0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
            m_ready     <= 1'b0;
        end else if (!sink_stalls_on) begin
            m_ready <= 1'b1;
        end else begin
            if (ready_phase == 0)
                ready_bits = $urandom | $urandom;
            m_ready     <= ready_bits[ready_phase];
            ready_phase = ready_phase + 5'd1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: each delivered hash against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_hashes.size() == 0) begin
                $display("%0t: unexpected hash, expected none, actual %h",
                         $time, m_hash_value);
                fail_count++;
            end else begin
                want_hash = expected_hashes.pop_front();
                if (m_hash_value !== want_hash) begin
                    $display("%0t: hash_value mismatch, expected %h, actual %h",
                             $time, want_hash, m_hash_value);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("four_lane_multiply_rotate_hash64 verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [63:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic queue_txn(input logic func, input logic [63:0] word,
                             input logic [31:0] len, input bit counted);
        hash_txn_t t;
        t.func = func;
        t.word = word;
        t.len  = len;
        pending_txns.push_back(t);
        txn_queued++;
        if (counted)
            counted_items++;
    endtask

    task automatic queue_words(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            queue_txn(FUNC_DATA, rand_word(), $urandom, 1'b1);
    endtask

    // a complete message with random content
    task automatic queue_message(input logic [31:0] len);
        queue_txn(FUNC_START, rand_word(), len, 1'b1);
        queue_words((len + 7) / 8);
        gen_open = 1'b0;
    endtask

    // wait until every transaction is taken and every hash delivered
    task automatic wait_idle();
        while (txn_taken != txn_queued || expected_hashes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // apb write of the seed, then a read back
    task automatic cfg_write_seed(input logic [63:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEED_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        seed_model = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== seed_model) begin
            $display("%0t: seed_value read back, expected %h, actual %h",
                     $time, seed_model, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random mix of well-formed, abandoned, oversized and stray traffic
    task automatic run_random_phase(input bit gaps_on, input bit stalls_on,
                                    input bit long_hold);
        int unsigned phase_base;
        int unsigned pick;
        int unsigned size_pick;
        logic [31:0] len;
        phase_base     = counted_items;
        sender_gaps_on = gaps_on;
        sink_stalls_on = stalls_on;
        if (long_hold)
            hold_requests++;
        while (counted_items - phase_base < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                size_pick = $urandom_range(0, 19);
                if (size_pick < 16)
                    len = $urandom_range(1, 72);
                else if (size_pick < 19)
                    len = $urandom_range(73, 200);
                else
                    len = $urandom_range(201, 400);
                queue_message(len);
            end else if (pick < 72) begin
                // message cut short, dropped by the next start
                len = $urandom_range(9, 200);
                queue_txn(FUNC_START, rand_word(), len, 1'b1);
                queue_words($urandom_range(0, (len + 7) / 8 - 1));
                gen_open = 1'b1;
            end else if (pick < 80) begin
                // very long message that never completes
                len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
                queue_txn(FUNC_START, rand_word(), len, 1'b1);
                queue_words($urandom_range(0, 6));
                gen_open = 1'b1;
            end else if (pick < 90 && !gen_open) begin
                // stray words with no message open
                for (int unsigned i = $urandom_range(1, 3); i != 0; i--)
                    queue_txn(FUNC_DATA, rand_word(), $urandom, 1'b0);
            end else begin
                queue_txn(FUNC_START, rand_word(), '0, 1'b1);
                gen_open = 1'b0;
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed cases on the reset seed
        // zero length hashes on the start itself
        queue_txn(FUNC_START, '1, '0, 1'b1);
        // single byte tail, upper bytes must be dropped
        queue_txn(FUNC_START, '0, 32'd1, 1'b1);
        queue_txn(FUNC_DATA, '1, '1, 1'b1);
        // one whole word, no block
        queue_txn(FUNC_START, '1, 32'd8, 1'b1);
        queue_txn(FUNC_DATA, '1, '0, 1'b1);
        // just short of a block: three whole words and a seven byte tail
        queue_txn(FUNC_START, '0, 32'd31, 1'b1);
        queue_txn(FUNC_DATA, '0, '1, 1'b1);
        queue_txn(FUNC_DATA, '1, '0, 1'b1);
        queue_txn(FUNC_DATA, rand_word(), $urandom, 1'b1);
        queue_txn(FUNC_DATA, '1, '1, 1'b1);
        // exactly one block across all four lanes
        queue_txn(FUNC_START, rand_word(), 32'd32, 1'b1);
        queue_words(4);
        // data with no message open is ignored
        queue_txn(FUNC_DATA, '1, '1, 1'b1);
        // open message abandoned by a new start
        queue_txn(FUNC_START, rand_word(), 32'd40, 1'b1);
        queue_words(2);
        // block followed by a one byte tail
        queue_txn(FUNC_START, rand_word(), 32'd33, 1'b1);
        queue_words(4);
        queue_txn(FUNC_DATA, '1, '1, 1'b1);
        wait_idle();

        cfg_write_seed('1);
        run_random_phase(1'b1, 1'b1, 1'b0);

        // seed change inside an open message only affects the next start
        queue_txn(FUNC_START, rand_word(), 32'd40, 1'b1);
        queue_words(2);
        gen_open = 1'b1;
        wait_idle();
        cfg_write_seed({$urandom, $urandom});
        queue_words(3);
        gen_open = 1'b0;
        run_random_phase(1'b0, 1'b0, 1'b0);

        cfg_write_seed(64'h1);
        run_random_phase(1'b1, 1'b1, 1'b1);

        cfg_write_seed(64'h8000_0000_0000_0000);
        run_random_phase(1'b1, 1'b0, 1'b0);

        cfg_write_seed({$urandom, $urandom});
        run_random_phase(1'b0, 1'b1, 1'b0);

        cfg_write_seed('0);
        run_random_phase(1'b1, 1'b1, 1'b0);

        if (fail_count == 0)
            $display("four_lane_multiply_rotate_hash64 verification clean");
        else
            $display("four_lane_multiply_rotate_hash64 verification failed");
        $finish;
    end

endmodule
